// File: design/ber_tlv_stream_parser_assert.svh
// Assertion macros for the BER TLV stream parser.
// Needs no package; the caller supplies clock, reset and expressions.
`ifndef BER_TLV_STREAM_PARSER_ASSERT_SVH
`define BER_TLV_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BTSP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btsp: same-cycle check failed");

// Next-cycle implication, off during reset.
`define BTSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btsp: next-cycle check failed");

`endif

// File: design/btsp_pkg.sv
// Shared types and codes for the BER TLV stream parser.
// No dependencies.
package btsp_pkg;

   localparam int BUF_LEN_FIELD_BITS = 16;
   localparam int RSP_FIFO_DEPTH     = 4;
   localparam int RSP_PTR_BITS       = 2;

   localparam logic [2:0] KIND_INT       = 3'd0;
   localparam logic [2:0] KIND_STR_BYTE  = 3'd1;
   localparam logic [2:0] KIND_STR_EMPTY = 3'd2;
   localparam logic [2:0] KIND_OK        = 3'd3;
   localparam logic [2:0] KIND_FAIL      = 3'd4;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_TAG   = 3'd1;
   localparam logic [2:0] ERR_LONG  = 3'd2;
   localparam logic [2:0] ERR_FORM  = 3'd3;
   localparam logic [2:0] ERR_TRUNC = 3'd4;

   typedef struct packed {
      logic [7:0]                    data_byte;
      logic                          start_req;
      logic [BUF_LEN_FIELD_BITS-1:0] buffer_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] value;
      logic        string_end;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } res_pair_type;

endpackage

// File: design/ber_tlv_stream_parser.sv
// BER TLV stream parser, top level: input register, parser and result queue.
// Depends on btsp_pkg, btsp_parser and ber_tlv_stream_parser_assert.svh.
//
// Takes one encoded byte per request and may take a request in every cycle
// while req_stall is low. Each byte is registered in the input register,
// decoded in a single pass against the parser state, and its zero, one or two
// results are written into a four-entry result queue that drives the rsp_ port.
// The result port moves one result per cycle while rsp_stall is low: a stream
// of bytes that give at most one result each runs at one byte per cycle, and
// bytes that give two results (a value followed by the end-of-buffer result)
// fill the queue faster than it drains. req_stall rises while a byte waits in
// the input register and the queue has fewer than two free entries.
`include "ber_tlv_stream_parser_assert.svh"

module ber_tlv_stream_parser import btsp_pkg::*; #(
   parameter int MAX_LENGTH_BYTES   = 8,
   parameter int BUFFER_LENGTH_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                  stage_valid_ff, stage_valid_in;
   req_type               stage_item_ff;
   rsp_type               fifo_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_BITS:0]   count_ff, count_in;
   logic [RSP_PTR_BITS-1:0] wr_ptr_next;

   logic                  room;
   logic                  step_en;
   logic                  req_accept;
   logic                  pop;
   logic [1:0]            push_count;
   res_pair_type          res;

   assign room       = count_ff <= (RSP_PTR_BITS+1)'(RSP_FIFO_DEPTH - 2);
   assign step_en    = stage_valid_ff && room;
   assign req_stall  = stage_valid_ff && !room;
   assign req_accept = req_valid && !req_stall;
   assign pop        = rsp_valid && !rsp_stall;
   assign push_count = step_en ? res.count : 2'd0;

   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = fifo_ff[rd_ptr_ff];

   assign stage_valid_in = req_accept || (stage_valid_ff && !step_en);
   assign wr_ptr_next    = wr_ptr_ff + RSP_PTR_BITS'(1);
   assign wr_ptr_in      = wr_ptr_ff + RSP_PTR_BITS'(push_count);
   assign rd_ptr_in      = rd_ptr_ff + RSP_PTR_BITS'(pop);
   assign count_in       = count_ff + (RSP_PTR_BITS+1)'(push_count)
                           - (RSP_PTR_BITS+1)'(pop);

   btsp_parser #(
      .MAX_LENGTH_BYTES   (MAX_LENGTH_BYTES),
      .BUFFER_LENGTH_BITS (BUFFER_LENGTH_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (stage_item_ff),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) stage_item_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) fifo_ff[wr_ptr_ff] <= res.first;
      if (push_count == 2'd2) fifo_ff[wr_ptr_next] <= res.second;
   end

   `BTSP_ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1,
      count_ff <= (RSP_PTR_BITS+1)'(RSP_FIFO_DEPTH))

   `BTSP_ASSERT_IMPLIES(a_last_marks_end, clock, reset, step_en && res.count != 2'd0,
      (res.count == 2'd1 && res.first.last) ||
      (res.count == 2'd2 && !res.first.last && res.second.last))

   `BTSP_ASSERT_IMPLIES(a_terminal_is_final, clock, reset, step_en && res.count == 2'd2,
      (res.first.kind == KIND_INT || res.first.kind == KIND_STR_BYTE ||
       res.first.kind == KIND_STR_EMPTY) &&
      (res.second.kind == KIND_OK || res.second.kind == KIND_FAIL))

   `BTSP_ASSERT_NEXT(a_pop_only, clock, reset, pop && push_count == 2'd0,
      count_ff == $past(count_ff) - (RSP_PTR_BITS+1)'(1))

endmodule

// File: design/btsp_parser.sv
// Parser state and per-byte decode: one request in, up to two results out.
// Depends on btsp_pkg.
module btsp_parser import btsp_pkg::*; #(
   parameter int MAX_LENGTH_BYTES   = 8,
   parameter int BUFFER_LENGTH_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_type      item,
   output res_pair_type res
);

   localparam int LEN_ACC_BITS = 8 * MAX_LENGTH_BYTES;
   localparam int BLB          = BUFFER_LENGTH_BITS;

   localparam logic [1:0] PH_TAG   = 2'd0;
   localparam logic [1:0] PH_LEN1  = 2'd1;
   localparam logic [1:0] PH_LENX  = 2'd2;
   localparam logic [1:0] PH_VALUE = 2'd3;

   localparam logic [1:0] TK_ENTER = 2'd0;
   localparam logic [1:0] TK_INT   = 2'd1;
   localparam logic [1:0] TK_STR   = 2'd2;
   localparam logic [1:0] TK_OID   = 2'd3;

   localparam logic [7:0] TAG_SEQUENCE = 8'h30;
   localparam logic [7:0] TAG_RESP_PDU = 8'hA2;
   localparam logic [7:0] TAG_INTEGER  = 8'h02;
   localparam logic [7:0] TAG_STRING   = 8'h04;
   localparam logic [7:0] TAG_OID      = 8'h06;

   logic [1:0]              phase_ff, phase_in;
   logic [BLB-1:0]          remaining_ff, remaining_in;
   logic [LEN_ACC_BITS-1:0] len_acc_ff, len_acc_in;
   logic [3:0]              len_left_ff, len_left_in;
   logic [1:0]              tag_kind_ff, tag_kind_in;
   logic [63:0]             int_acc_ff, int_acc_in;
   logic [BLB-1:0]          value_left_ff, value_left_in;
   logic                    halted_ff, halted_in;

   logic [31:0]             len_wide;
   logic [BLB-1:0]          start_len;
   logic [BLB-1:0]          rem;
   logic [7:0]              b;
   logic [6:0]              len_count;
   logic                    do_finish;
   logic [LEN_ACC_BITS-1:0] hdr_len;
   logic [63:0]             hdr_len64;
   logic                    ok;
   logic                    data_valid;
   rsp_type                 data_res;
   logic                    term_valid;
   rsp_type                 term_res;

   function automatic rsp_type make_rsp(logic [2:0] kind, logic [63:0] value,
                                        logic send, logic [2:0] err);
      rsp_type r;
      r.kind       = kind;
      r.value      = value;
      r.string_end = send;
      r.error_code = err;
      r.last       = 1'b0;
      return r;
   endfunction

   assign len_wide  = 32'(item.buffer_length);
   assign start_len = len_wide[BLB-1:0];
   assign b         = item.data_byte;
   assign len_count = b[6:0];

   always_comb begin
      phase_in      = phase_ff;
      remaining_in  = remaining_ff;
      len_acc_in    = len_acc_ff;
      len_left_in   = len_left_ff;
      tag_kind_in   = tag_kind_ff;
      int_acc_in    = int_acc_ff;
      value_left_in = value_left_ff;
      halted_in     = halted_ff;
      rem           = '0;
      do_finish     = 1'b0;
      hdr_len       = '0;
      hdr_len64     = '0;
      ok            = 1'b1;
      data_valid    = 1'b0;
      data_res      = '0;
      term_valid    = 1'b0;
      term_res      = '0;

      if (item.start_req) begin
         phase_in      = PH_TAG;
         remaining_in  = start_len;
         len_acc_in    = '0;
         len_left_in   = '0;
         tag_kind_in   = TK_ENTER;
         int_acc_in    = '0;
         value_left_in = '0;
         halted_in     = 1'b0;
         if (start_len == '0) begin
            term_valid = 1'b1;
            term_res   = make_rsp(KIND_OK, 64'd0, 1'b0, ERR_NONE);
            halted_in  = 1'b1;
         end
      end

      if (!halted_in) begin
         rem          = remaining_in - BLB'(1);
         remaining_in = rem;
         unique case (phase_in)
            PH_TAG: begin
               priority if (b == TAG_SEQUENCE || b == TAG_RESP_PDU) tag_kind_in = TK_ENTER;
               else if (b == TAG_INTEGER) tag_kind_in = TK_INT;
               else if (b == TAG_STRING) tag_kind_in = TK_STR;
               else if (b == TAG_OID) tag_kind_in = TK_OID;
               else begin
                  ok         = 1'b0;
                  term_valid = 1'b1;
                  term_res   = make_rsp(KIND_FAIL, 64'd0, 1'b0, ERR_TAG);
               end
               if (ok) begin
                  if (rem < BLB'(2)) begin
                     ok         = 1'b0;
                     term_valid = 1'b1;
                     term_res   = make_rsp(KIND_FAIL, 64'd0, 1'b0, ERR_TRUNC);
                  end else begin
                     phase_in = PH_LEN1;
                  end
               end
            end
            PH_LEN1: begin
               if (b[7]) begin
                  if (len_count == 7'd0 || len_count > 7'(MAX_LENGTH_BYTES)) begin
                     ok         = 1'b0;
                     term_valid = 1'b1;
                     term_res   = make_rsp(KIND_FAIL, 64'd0, 1'b0, ERR_FORM);
                  end else begin
                     len_left_in = len_count[3:0];
                     len_acc_in  = '0;
                     phase_in    = PH_LENX;
                  end
               end else begin
                  len_acc_in = LEN_ACC_BITS'(b);
                  hdr_len    = LEN_ACC_BITS'(b);
                  do_finish  = 1'b1;
               end
            end
            PH_LENX: begin
               len_acc_in  = (len_acc_ff << 8) | LEN_ACC_BITS'(b);
               len_left_in = len_left_ff - 4'd1;
               if (len_left_in == 4'd0) begin
                  hdr_len   = len_acc_in;
                  do_finish = 1'b1;
               end else if (rem == '0) begin
                  ok         = 1'b0;
                  term_valid = 1'b1;
                  term_res   = make_rsp(KIND_FAIL, 64'd0, 1'b0, ERR_TRUNC);
               end
            end
            PH_VALUE: begin
               value_left_in = value_left_ff - BLB'(1);
               if (tag_kind_ff == TK_INT) begin
                  int_acc_in = {int_acc_ff[55:0], b};
                  if (value_left_in == '0) begin
                     data_valid = 1'b1;
                     data_res   = make_rsp(KIND_INT, int_acc_in, 1'b0, ERR_NONE);
                  end
               end else if (tag_kind_ff == TK_STR) begin
                  data_valid = 1'b1;
                  data_res   = make_rsp(KIND_STR_BYTE, 64'(b), value_left_in == '0,
                                        ERR_NONE);
               end
               if (value_left_in == '0) phase_in = PH_TAG;
            end
            default: phase_in = PH_TAG;
         endcase

         if (do_finish) begin
            hdr_len64 = 64'(hdr_len);
            if (hdr_len64[63]) begin
               ok         = 1'b0;
               term_valid = 1'b1;
               term_res   = make_rsp(KIND_FAIL, 64'd0, 1'b0, ERR_FORM);
            end else if (hdr_len64 > 64'(rem)) begin
               ok         = 1'b0;
               term_valid = 1'b1;
               term_res   = make_rsp(KIND_FAIL, 64'd0, 1'b0, ERR_LONG);
            end else begin
               phase_in = PH_TAG;
               if (tag_kind_in != TK_ENTER) begin
                  if (tag_kind_in == TK_INT) int_acc_in = '0;
                  if (hdr_len64 == 64'd0) begin
                     if (tag_kind_in == TK_INT) begin
                        data_valid = 1'b1;
                        data_res   = make_rsp(KIND_INT, 64'd0, 1'b0, ERR_NONE);
                     end else if (tag_kind_in == TK_STR) begin
                        data_valid = 1'b1;
                        data_res   = make_rsp(KIND_STR_EMPTY, 64'd0, 1'b0, ERR_NONE);
                     end
                  end else begin
                     value_left_in = hdr_len64[BLB-1:0];
                     phase_in      = PH_VALUE;
                  end
               end
            end
         end

         if (!ok) begin
            halted_in = 1'b1;
         end else if (rem == '0) begin
            term_valid = 1'b1;
            if (phase_in == PH_TAG) begin
               term_res = make_rsp(KIND_OK, 64'd0, 1'b0, ERR_NONE);
            end else begin
               term_res = make_rsp(KIND_FAIL, 64'd0, 1'b0, ERR_TRUNC);
            end
            halted_in = 1'b1;
         end
      end
   end

   always_comb begin
      res = '0;
      if (data_valid) begin
         res.first      = data_res;
         res.first.last = !term_valid;
         res.second     = term_res;
         res.second.last = 1'b1;
         res.count      = term_valid ? 2'd2 : 2'd1;
      end else if (term_valid) begin
         res.first      = term_res;
         res.first.last = 1'b1;
         res.count      = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TAG;
         remaining_ff  <= '0;
         len_acc_ff    <= '0;
         len_left_ff   <= '0;
         tag_kind_ff   <= TK_ENTER;
         int_acc_ff    <= '0;
         value_left_ff <= '0;
         halted_ff     <= 1'b1;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         len_acc_ff    <= len_acc_in;
         len_left_ff   <= len_left_in;
         tag_kind_ff   <= tag_kind_in;
         int_acc_ff    <= int_acc_in;
         value_left_ff <= value_left_in;
         halted_ff     <= halted_in;
      end
   end

endmodule
